FILE: design/cpt_pkg.sv
// Shared types and constants for the collision pair test pipeline.
// Used by every module of the block; depends on nothing else.
package cpt_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int NUM_MUL         = 8;

  typedef enum logic [1:0] {
    FUNC_SEG      = 2'd0,
    FUNC_CIRCLE   = 2'd1,
    FUNC_BOX      = 2'd2,
    FUNC_CIRC_BOX = 2'd3
  } func_t;

  // Per-stage load enables, one per pipeline register stage.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } cpt_adv_t;

  // Side information that travels with each request next to the products.
  typedef struct packed {
    func_t      func;
    logic       box_hit;
    logic       s_neg;
    logic       r_nonpos;
    logic [3:0] on_seg;
  } cpt_side_t;

endpackage

FILE: design/cpt_prep.sv
// Front end of the collision pipeline: differences and box tests (stage 1),
// then clamps and multiplier operand selection (stage 2). Uses cpt_pkg.
module cpt_prep
  import cpt_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                            clk,
  input  cpt_adv_t                        adv,
  input  func_t                           func,
  input  logic [8*COORD_WIDTH-1:0]        points,
  output cpt_side_t                       side_r,
  output logic signed [COORD_WIDTH+2:0]   op_a_r [NUM_MUL],
  output logic signed [COORD_WIDTH+2:0]   op_b_r [NUM_MUL]
);

  localparam int W  = COORD_WIDTH;
  localparam int OW = COORD_WIDTH + 3;

  logic signed [W-1:0] ax, ay, bx, by, cx, cy, dx, dy;

  assign ax = $signed(points[0*W +: W]);
  assign ay = $signed(points[1*W +: W]);
  assign bx = $signed(points[2*W +: W]);
  assign by = $signed(points[3*W +: W]);
  assign cx = $signed(points[4*W +: W]);
  assign cy = $signed(points[5*W +: W]);
  assign dx = $signed(points[6*W +: W]);
  assign dy = $signed(points[7*W +: W]);

  // True when q lies between p and r, whichever of the two is larger.
  function automatic logic btw(input logic signed [W-1:0] p,
                               input logic signed [W-1:0] q,
                               input logic signed [W-1:0] r);
    return (q <= p || q <= r) && (q >= p || q >= r);
  endfunction

  // Stage 1 next values.
  logic signed [OW-1:0] d_ba_x_nxt, d_ba_y_nxt, d_cb_x_nxt, d_cb_y_nxt;
  logic signed [OW-1:0] d_db_x_nxt, d_db_y_nxt, d_dc_x_nxt, d_dc_y_nxt;
  logic signed [OW-1:0] d_ad_x_nxt, d_ad_y_nxt, d_bd_x_nxt, d_bd_y_nxt;
  logic signed [OW-1:0] rsum_nxt, r2_nxt;
  logic signed [OW-1:0] dlo_x_nxt, dhi_x_nxt, dlo_y_nxt, dhi_y_nxt;
  logic signed [OW-1:0] b1_lo_x, b1_hi_x, b2_lo_x, b2_hi_x;
  logic signed [OW-1:0] b1_lo_y, b1_hi_y, b2_lo_y, b2_hi_y;
  cpt_side_t            side1_nxt;

  // Stage 1 registers.
  logic signed [OW-1:0] d_ba_x_r, d_ba_y_r, d_cb_x_r, d_cb_y_r;
  logic signed [OW-1:0] d_db_x_r, d_db_y_r, d_dc_x_r, d_dc_y_r;
  logic signed [OW-1:0] d_ad_x_r, d_ad_y_r, d_bd_x_r, d_bd_y_r;
  logic signed [OW-1:0] rsum_r, r2_r;
  logic signed [OW-1:0] dlo_x_r, dhi_x_r, dlo_y_r, dhi_y_r;
  logic                 cross_x_r, cross_y_r;
  cpt_side_t            side1_r;

  always_comb begin
    d_ba_x_nxt = OW'(bx) - OW'(ax);
    d_ba_y_nxt = OW'(by) - OW'(ay);
    d_cb_x_nxt = OW'(cx) - OW'(bx);
    d_cb_y_nxt = OW'(cy) - OW'(by);
    d_db_x_nxt = OW'(dx) - OW'(bx);
    d_db_y_nxt = OW'(dy) - OW'(by);
    d_dc_x_nxt = OW'(dx) - OW'(cx);
    d_dc_y_nxt = OW'(dy) - OW'(cy);
    d_ad_x_nxt = OW'(ax) - OW'(dx);
    d_ad_y_nxt = OW'(ay) - OW'(dy);
    d_bd_x_nxt = OW'(bx) - OW'(dx);
    d_bd_y_nxt = OW'(by) - OW'(dy);
    rsum_nxt   = OW'(cx) + OW'(cy);
    r2_nxt     = OW'(dx) + OW'(dx);

    // Box bounds in doubled coordinates, so half sizes stay integer.
    b1_lo_x = OW'(ax) + OW'(ax) - OW'(cx);
    b1_hi_x = OW'(ax) + OW'(ax) + OW'(cx);
    b2_lo_x = OW'(bx) + OW'(bx) - OW'(dx);
    b2_hi_x = OW'(bx) + OW'(bx) + OW'(dx);
    b1_lo_y = OW'(ay) + OW'(ay) - OW'(cy);
    b1_hi_y = OW'(ay) + OW'(ay) + OW'(cy);
    b2_lo_y = OW'(by) + OW'(by) - OW'(dy);
    b2_hi_y = OW'(by) + OW'(by) + OW'(dy);

    // Box bounds relative to the doubled circle center.
    dlo_x_nxt = b1_lo_x - OW'(bx) - OW'(bx);
    dhi_x_nxt = b1_hi_x - OW'(bx) - OW'(bx);
    dlo_y_nxt = b1_lo_y - OW'(by) - OW'(by);
    dhi_y_nxt = b1_hi_y - OW'(by) - OW'(by);

    side1_nxt.func      = func;
    side1_nxt.box_hit   = (b1_lo_x <= b2_hi_x) && (b1_hi_x >= b2_lo_x) &&
                          (b1_lo_y <= b2_hi_y) && (b1_hi_y >= b2_lo_y);
    side1_nxt.s_neg     = 1'b0;
    side1_nxt.r_nonpos  = dx[W-1] || (dx == '0);
    side1_nxt.on_seg[0] = btw(ax, cx, bx) && btw(ay, cy, by);
    side1_nxt.on_seg[1] = btw(ax, dx, bx) && btw(ay, dy, by);
    side1_nxt.on_seg[2] = btw(cx, ax, dx) && btw(cy, ay, dy);
    side1_nxt.on_seg[3] = btw(cx, bx, dx) && btw(cy, by, dy);
  end

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      d_ba_x_r  <= d_ba_x_nxt;
      d_ba_y_r  <= d_ba_y_nxt;
      d_cb_x_r  <= d_cb_x_nxt;
      d_cb_y_r  <= d_cb_y_nxt;
      d_db_x_r  <= d_db_x_nxt;
      d_db_y_r  <= d_db_y_nxt;
      d_dc_x_r  <= d_dc_x_nxt;
      d_dc_y_r  <= d_dc_y_nxt;
      d_ad_x_r  <= d_ad_x_nxt;
      d_ad_y_r  <= d_ad_y_nxt;
      d_bd_x_r  <= d_bd_x_nxt;
      d_bd_y_r  <= d_bd_y_nxt;
      rsum_r    <= rsum_nxt;
      r2_r      <= r2_nxt;
      dlo_x_r   <= dlo_x_nxt;
      dhi_x_r   <= dhi_x_nxt;
      dlo_y_r   <= dlo_y_nxt;
      dhi_y_r   <= dhi_y_nxt;
      cross_x_r <= cx[W-1];
      cross_y_r <= cy[W-1];
      side1_r   <= side1_nxt;
    end
  end

  // Stage 2: clamp offset and operand selection.
  logic signed [OW-1:0] cb_x, cb_y;
  logic signed [OW-1:0] op_a_nxt [NUM_MUL];
  logic signed [OW-1:0] op_b_nxt [NUM_MUL];
  cpt_side_t            side2_nxt;

  always_comb begin
    // Clamped point minus circle center; bounds that cross clamp to the low one.
    if (cross_x_r || (!dlo_x_r[OW-1] && dlo_x_r != '0)) begin
      cb_x = dlo_x_r;
    end else if (dhi_x_r[OW-1]) begin
      cb_x = dhi_x_r;
    end else begin
      cb_x = '0;
    end
    if (cross_y_r || (!dlo_y_r[OW-1] && dlo_y_r != '0)) begin
      cb_y = dlo_y_r;
    end else if (dhi_y_r[OW-1]) begin
      cb_y = dhi_y_r;
    end else begin
      cb_y = '0;
    end

    for (int i = 0; i < NUM_MUL; i++) begin
      op_a_nxt[i] = '0;
      op_b_nxt[i] = '0;
    end

    case (side1_r.func)
      FUNC_SEG: begin
        op_a_nxt[0] = d_ba_y_r; op_b_nxt[0] = d_cb_x_r;
        op_a_nxt[1] = d_ba_x_r; op_b_nxt[1] = d_cb_y_r;
        op_a_nxt[2] = d_ba_y_r; op_b_nxt[2] = d_db_x_r;
        op_a_nxt[3] = d_ba_x_r; op_b_nxt[3] = d_db_y_r;
        op_a_nxt[4] = d_dc_y_r; op_b_nxt[4] = d_ad_x_r;
        op_a_nxt[5] = d_dc_x_r; op_b_nxt[5] = d_ad_y_r;
        op_a_nxt[6] = d_dc_y_r; op_b_nxt[6] = d_bd_x_r;
        op_a_nxt[7] = d_dc_x_r; op_b_nxt[7] = d_bd_y_r;
      end
      FUNC_CIRCLE: begin
        op_a_nxt[0] = rsum_r;   op_b_nxt[0] = rsum_r;
        op_a_nxt[1] = d_ba_x_r; op_b_nxt[1] = d_ba_x_r;
        op_a_nxt[2] = d_ba_y_r; op_b_nxt[2] = d_ba_y_r;
      end
      FUNC_CIRC_BOX: begin
        op_a_nxt[0] = r2_r; op_b_nxt[0] = r2_r;
        op_a_nxt[1] = cb_x; op_b_nxt[1] = cb_x;
        op_a_nxt[2] = cb_y; op_b_nxt[2] = cb_y;
      end
      default: begin
      end
    endcase

    side2_nxt       = side1_r;
    side2_nxt.s_neg = rsum_r[OW-1];
  end

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      for (int i = 0; i < NUM_MUL; i++) begin
        op_a_r[i] <= op_a_nxt[i];
        op_b_r[i] <= op_b_nxt[i];
      end
      side_r <= side2_nxt;
    end
  end

endmodule

FILE: design/cpt_mul.sv
// Multiplier stage of the collision pipeline: eight signed products,
// registered (stage 3). Uses cpt_pkg.
module cpt_mul
  import cpt_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                              clk,
  input  cpt_adv_t                          adv,
  input  cpt_side_t                         side_in,
  input  logic signed [COORD_WIDTH+2:0]     op_a [NUM_MUL],
  input  logic signed [COORD_WIDTH+2:0]     op_b [NUM_MUL],
  output cpt_side_t                         side_r,
  output logic signed [2*COORD_WIDTH+5:0]   prod_r [NUM_MUL]
);

  localparam int PW = 2 * (COORD_WIDTH + 3);

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      for (int i = 0; i < NUM_MUL; i++) begin
        prod_r[i] <= PW'(op_a[i]) * PW'(op_b[i]);
      end
      side_r <= side_in;
    end
  end

endmodule

FILE: design/cpt_decide.sv
// Decision stages of the collision pipeline: orientation signs and squared
// distance compares (stage 4), then the selected hit bit (stage 5). Uses cpt_pkg.
module cpt_decide
  import cpt_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                              clk,
  input  cpt_adv_t                          adv,
  input  cpt_side_t                         side_in,
  input  logic signed [2*COORD_WIDTH+5:0]   prod [NUM_MUL],
  output logic                              hit_r
);

  localparam int PW = 2 * (COORD_WIDTH + 3);
  localparam int DW = PW + 2;

  typedef enum logic [1:0] {
    ORI_COL = 2'd0,
    ORI_CW  = 2'd1,
    ORI_CCW = 2'd2
  } orient_t;

  logic signed [DW-1:0] odiff [4];
  logic signed [DW-1:0] sqd;
  orient_t              ori_nxt [4];
  orient_t              ori_r [4];
  logic                 d_pos_r, d_nneg_r;
  cpt_side_t            side4_r;
  logic                 seg_hit, hit_nxt;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      odiff[k] = DW'(prod[2*k]) - DW'(prod[2*k+1]);
      if (odiff[k] == '0) begin
        ori_nxt[k] = ORI_COL;
      end else if (odiff[k][DW-1]) begin
        ori_nxt[k] = ORI_CCW;
      end else begin
        ori_nxt[k] = ORI_CW;
      end
    end
    // Squared reach minus squared distance, for both circle tests.
    sqd = DW'(prod[0]) - DW'(prod[1]) - DW'(prod[2]);
  end

  always_ff @(posedge clk) begin
    if (adv.s4) begin
      for (int k = 0; k < 4; k++) begin
        ori_r[k] <= ori_nxt[k];
      end
      d_pos_r  <= !sqd[DW-1] && (sqd != '0);
      d_nneg_r <= !sqd[DW-1];
      side4_r  <= side_in;
    end
  end

  always_comb begin
    seg_hit = (ori_r[0] != ori_r[1] && ori_r[2] != ori_r[3]) ||
              (ori_r[0] == ORI_COL && side4_r.on_seg[0]) ||
              (ori_r[1] == ORI_COL && side4_r.on_seg[1]) ||
              (ori_r[2] == ORI_COL && side4_r.on_seg[2]) ||
              (ori_r[3] == ORI_COL && side4_r.on_seg[3]);
    case (side4_r.func)
      FUNC_SEG:      hit_nxt = seg_hit;
      FUNC_CIRCLE:   hit_nxt = !side4_r.s_neg && d_nneg_r;
      FUNC_BOX:      hit_nxt = side4_r.box_hit;
      FUNC_CIRC_BOX: hit_nxt = !side4_r.r_nonpos && d_pos_r;
      default:       hit_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv.s5) begin
      hit_r <= hit_nxt;
    end
  end

endmodule

FILE: design/collision_pair_test.sv
// Top level of the 2D collision test unit: stream handshake, stage valid
// bits and the three pipeline modules. Uses cpt_pkg, cpt_prep, cpt_mul, cpt_decide.
//
// Usage: each request on the in_ channel carries a test selector in in_tuser
// (segment pair, circle pair, box pair, circle versus box) and four points in
// in_tdata. Exactly one result leaves on the out_ channel per request, in
// request order; out_tdata bit 0 is the hit flag.
// The block is a five-stage pipeline: differences and box compares, operand
// selection and clamp, eight parallel multipliers, sign and distance compares,
// and the output register. out_tvalid rises once the request reaches the output
// register. Throughput is one request per cycle while out_tready stays high,
// since every stage then takes a new request each cycle.
// Each stage loads when it is empty or the stage after it moves, so empty
// slots close up and a request is still taken while a result waits.
// When the receiver holds out_tready low, stages fill up and in_tready drops
// once all five are occupied; nothing is lost or repeated.
// Synchronous reset empties the pipeline; no request is pending afterward.
module collision_pair_test
  import cpt_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // in_tdata, low to high: point1_x, point1_y, point2_x, point2_y,
  // point3_x, point3_y, point4_x, point4_y
  input  logic [8*COORD_WIDTH-1:0]   in_tdata,
  // in_tuser: func
  input  logic [1:0]                 in_tuser,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // out_tdata, low to high: hit, then zero fill
  output logic [7:0]                 out_tdata
);

  localparam int OW = COORD_WIDTH + 3;
  localparam int PW = 2 * OW;

  cpt_adv_t             adv;
  logic [4:0]           valid_r, valid_nxt;
  cpt_side_t            side2, side3;
  logic signed [OW-1:0] op_a [NUM_MUL];
  logic signed [OW-1:0] op_b [NUM_MUL];
  logic signed [PW-1:0] prod [NUM_MUL];
  logic                 hit;

  always_comb begin
    adv.s5 = !valid_r[4] || out_tready;
    adv.s4 = !valid_r[3] || adv.s5;
    adv.s3 = !valid_r[2] || adv.s4;
    adv.s2 = !valid_r[1] || adv.s3;
    adv.s1 = !valid_r[0] || adv.s2;

    valid_nxt[0] = adv.s1 ? in_tvalid  : valid_r[0];
    valid_nxt[1] = adv.s2 ? valid_r[0] : valid_r[1];
    valid_nxt[2] = adv.s3 ? valid_r[1] : valid_r[2];
    valid_nxt[3] = adv.s4 ? valid_r[2] : valid_r[3];
    valid_nxt[4] = adv.s5 ? valid_r[3] : valid_r[4];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_tready  = adv.s1;
  assign out_tvalid = valid_r[4];
  assign out_tdata  = {{7{1'b0}}, hit};

  cpt_prep #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_prep (
    .clk    (clk),
    .adv    (adv),
    .func   (func_t'(in_tuser)),
    .points (in_tdata),
    .side_r (side2),
    .op_a_r (op_a),
    .op_b_r (op_b)
  );

  cpt_mul #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_mul (
    .clk     (clk),
    .adv     (adv),
    .side_in (side2),
    .op_a    (op_a),
    .op_b    (op_b),
    .side_r  (side3),
    .prod_r  (prod)
  );

  cpt_decide #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_decide (
    .clk     (clk),
    .adv     (adv),
    .side_in (side3),
    .prod    (prod),
    .hit_r   (hit)
  );

`ifndef NO_ASSERTIONS
  // Input back-pressure only when every stage holds a request.
  a_full_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (&valid_r))
    else $error("in_tready low while a pipeline stage is empty");

  // An accepted request occupies the first stage on the next cycle.
  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> valid_r[0])
    else $error("accepted request did not enter stage 1");

  // A moving request is never dropped between stages one and two.
  a_stage_move: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[0] && adv.s2 |=> valid_r[1])
    else $error("request lost between stage 1 and stage 2");

  // Reset leaves the pipeline empty.
  a_reset_empty: assert property (@(posedge clk)
    !$past(rst_n) |-> (valid_r == '0))
    else $error("pipeline not empty after reset");
`endif

endmodule
